>>> hdl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Commands, status codes and walk direction codes used by the heap queue unit
// ----------------------------------------------------------------------------
`default_nettype none
package imhq_pkg;

  localparam int ID_BITS = 10;
  localparam int ITEM_SPACE = 1024;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_CHANGE   = 3'd2,
    CMD_CONTAINS = 3'd3,
    CMD_PEEK     = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_PRESENT     = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  // walk direction for the shared compare/swap sequencer
  typedef enum logic [1:0] {
    WALK_SWIM   = 2'd0,
    WALK_SINK   = 2'd1,
    WALK_CHANGE = 2'd2
  } walk_t;

endpackage
`default_nettype wire

>>> hdl/imhq_ram.sv
// ----------------------------------------------------------------------------
// imhq_ram
// Single-port-write, single-port-read RAM with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module imhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/indexed_min_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_unit
// Indexed binary min-heap priority queue with add, remove_min, change
// priority, contains and peek, walked by one shared compare/swap sequencer
// ----------------------------------------------------------------------------
// flow: each request is read in S_LOOK and judged in S_DECIDE; contains, peek
//   and rejected requests then go to S_DONE, add swims, change swims or sinks,
//   and remove_min moves the last item to the top and sinks it
// handshake: one request at a time; in_tready is low while a request walks
//   and while its response waits
// reset: after rst_n a clearing pass zeroes every entry of the membership RAM;
//   no request is taken until it ends
`default_nettype none
module indexed_min_heap_queue_unit #(
  parameter int CAPACITY      = 1024,
  parameter int PRIORITY_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command[2:0], item_id[12:3], priority_req[44:13], zero fill
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0], item_out[12:3], priority_out[44:13], is_member[45],
  // count[56:46], zero fill
  output logic [63:0]      out_tdata
);

  localparam int IB = imhq_pkg::ID_BITS;
  localparam int IS = imhq_pkg::ITEM_SPACE;
  localparam int SB = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CB = $clog2(CAPACITY + 1);
  localparam int PB = PRIORITY_BITS;
  localparam int WB = SB + 2;

  typedef enum logic [16:0] {
    S_CLEAR  = 17'h00001,
    S_IDLE   = 17'h00002,
    S_LOOK   = 17'h00004,
    S_DECIDE = 17'h00008,
    S_RLAST  = 17'h00010,
    S_RLAST2 = 17'h00020,
    S_RTOP   = 17'h00040,
    S_UPRD   = 17'h00080,
    S_UPID   = 17'h00100,
    S_UPPRI  = 17'h00200,
    S_DNRD   = 17'h00400,
    S_DNL    = 17'h00800,
    S_DNR    = 17'h01000,
    S_DNSEL  = 17'h02000,
    S_CMP    = 17'h04000,
    S_SWAP2  = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // ram ports
  logic          hs_we;  logic [SB-1:0] hs_wa, hs_ra;  logic [IB-1:0] hs_wd, hs_rd;
  logic          pr_we;  logic [IB-1:0] pr_wa, pr_ra;  logic [PB-1:0] pr_wd, pr_rd;
  logic          ps_we;  logic [IB-1:0] ps_wa, ps_ra;  logic [SB-1:0] ps_wd, ps_rd;
  logic          mb_we;  logic [IB-1:0] mb_wa, mb_ra;  logic [0:0]    mb_wd, mb_rd;

  imhq_ram #(.WIDTH(IB), .DEPTH(1 << SB)) u_slots (
    .clk, .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));
  imhq_ram #(.WIDTH(PB), .DEPTH(IS)) u_prio (
    .clk, .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd));
  imhq_ram #(.WIDTH(SB), .DEPTH(IS)) u_pos (
    .clk, .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd));
  imhq_ram #(.WIDTH(1), .DEPTH(IS)) u_memb (
    .clk, .we(mb_we), .waddr(mb_wa), .wdata(mb_wd), .raddr(mb_ra), .rdata(mb_rd));

  // request and walk registers
  logic [2:0]    cmd_r;
  logic [IB-1:0] id_r;
  logic [PB-1:0] prio_r;
  logic [CB-1:0] count_r, count_nxt;
  logic [IB-1:0] clr_r;
  imhq_pkg::walk_t walk_r, walk_nxt;   // change: first swim test decides direction
  logic [SB-1:0] pos_r, pos_nxt, oth_r, oth_nxt, lft_r, lft_nxt;
  logic [IB-1:0] ida_r, ida_nxt, idb_r, idb_nxt, idl_r, idl_nxt;
  logic [PB-1:0] pa_r, pa_nxt, pb_r, pb_nxt, pl_r, pl_nxt;
  logic          hasr_r, hasr_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [IB-1:0] io_r, io_nxt;
  logic [31:0]   po_r, po_nxt;
  logic          mem_r, mem_nxt;
  logic          ovld_r;

  logic          in_acc;
  logic [63:0]   req_wide;
  logic [PB-1:0] req_prio;
  logic [PB-1:0] cmp_x, cmp_y;
  logic          lt;
  logic [SB:0]   lchild;

  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !ovld_r;

  assign req_wide = {32'd0, in_tdata[44:13]};
  assign req_prio = req_wide[PB-1:0];

  // single shared comparator, operands picked by the step
  always_comb begin
    cmp_x = pa_r;
    cmp_y = pb_r;
    if (state_r == S_DNSEL) begin
      cmp_x = pr_rd;
      cmp_y = pl_r;
    end else if (walk_r == imhq_pkg::WALK_SINK) begin
      cmp_x = pb_r;
      cmp_y = pa_r;
    end
  end

  assign lt = cmp_x < cmp_y;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    walk_nxt = walk_r;
    pos_nxt = pos_r;     oth_nxt = oth_r;   lft_nxt = lft_r;
    ida_nxt = ida_r;     idb_nxt = idb_r;   idl_nxt = idl_r;
    pa_nxt = pa_r;       pb_nxt = pb_r;     pl_nxt = pl_r;
    hasr_nxt = hasr_r;
    st_nxt = st_r;       io_nxt = io_r;     po_nxt = po_r;   mem_nxt = mem_r;
    lchild = {pos_r, 1'b1};
    hs_we = 1'b0; hs_wa = pos_r; hs_wd = ida_r; hs_ra = pos_r;
    pr_we = 1'b0; pr_wa = id_r;  pr_wd = prio_r; pr_ra = id_r;
    ps_we = 1'b0; ps_wa = ida_r; ps_wd = oth_r; ps_ra = id_r;
    mb_we = 1'b0; mb_wa = id_r;  mb_wd = 1'b0;  mb_ra = id_r;
    unique case (state_r)
      S_CLEAR: begin
        mb_we = 1'b1;
        mb_wa = clr_r;
        if (clr_r == IB'(IS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        mb_ra = in_tdata[12:3];
        ps_ra = in_tdata[12:3];
        hs_ra = '0;
        if (in_acc) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        // membership, position and top slot now readable; read top priority
        pr_ra = hs_rd;
        st_nxt = imhq_pkg::ST_OK; io_nxt = '0; po_nxt = '0; mem_nxt = 1'b0;
        state_nxt = S_DECIDE;
        pos_nxt = ps_rd;
        ida_nxt = hs_rd;
      end
      S_DECIDE: begin
        unique case (cmd_r) inside
          imhq_pkg::CMD_ADD: begin
            if (mb_rd[0]) begin
              st_nxt = imhq_pkg::ST_PRESENT; state_nxt = S_DONE;
            end else if (count_r >= CB'(CAPACITY)) begin
              st_nxt = imhq_pkg::ST_FULL; state_nxt = S_DONE;
            end else begin
              hs_we = 1'b1; hs_wa = SB'(count_r); hs_wd = id_r;
              pr_we = 1'b1;
              ps_we = 1'b1; ps_wa = id_r; ps_wd = SB'(count_r);
              mb_we = 1'b1; mb_wd = 1'b1;
              count_nxt = count_r + CB'(1);
              pos_nxt = SB'(count_r);
              ida_nxt = id_r; pa_nxt = prio_r;
              walk_nxt = imhq_pkg::WALK_SWIM;
              state_nxt = S_UPRD;
            end
          end
          imhq_pkg::CMD_REMOVE, imhq_pkg::CMD_PEEK: begin
            if (count_r == '0) begin
              st_nxt = imhq_pkg::ST_EMPTY; state_nxt = S_DONE;
            end else begin
              io_nxt = ida_r;
              po_nxt = 32'(pr_rd);
              if (cmd_r == imhq_pkg::CMD_PEEK) begin
                state_nxt = S_DONE;
              end else begin
                mb_we = 1'b1; mb_wa = ida_r; mb_wd = 1'b0;
                count_nxt = count_r - CB'(1);
                if (count_r == CB'(1)) state_nxt = S_DONE;
                else state_nxt = S_RLAST;
              end
            end
          end
          imhq_pkg::CMD_CHANGE: begin
            if (!mb_rd[0]) begin
              st_nxt = imhq_pkg::ST_NOT_PRESENT; state_nxt = S_DONE;
            end else if (WB'(pos_r) >= WB'(count_r)) begin
              state_nxt = S_DONE;
            end else begin
              pr_we = 1'b1;
              ida_nxt = id_r; pa_nxt = prio_r;
              walk_nxt = imhq_pkg::WALK_CHANGE;
              state_nxt = S_UPRD;
            end
          end
          imhq_pkg::CMD_CONTAINS: begin
            mem_nxt = mb_rd[0]; state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RLAST: begin
        // count already decremented: last slot index is count_r
        hs_ra = SB'(count_r);
        state_nxt = S_RLAST2;
      end
      S_RLAST2: begin
        pr_ra = hs_rd;
        hs_we = 1'b1; hs_wa = '0; hs_wd = hs_rd;
        ps_we = 1'b1; ps_wa = hs_rd; ps_wd = '0;
        ida_nxt = hs_rd; pos_nxt = '0;
        walk_nxt = imhq_pkg::WALK_SINK;
        state_nxt = S_RTOP;
      end
      S_RTOP: begin
        pa_nxt = pr_rd;
        state_nxt = S_DNRD;
      end
      S_UPRD: begin
        if (pos_r == '0) begin
          if (walk_r == imhq_pkg::WALK_CHANGE) begin
            walk_nxt = imhq_pkg::WALK_SINK;
            state_nxt = S_DNRD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          hs_ra = (pos_r - SB'(1)) >> 1;
          oth_nxt = (pos_r - SB'(1)) >> 1;
          state_nxt = S_UPID;
        end
      end
      S_UPID: begin
        pr_ra = hs_rd;
        idb_nxt = hs_rd;
        state_nxt = S_UPPRI;
      end
      S_UPPRI: begin
        pb_nxt = pr_rd;
        state_nxt = S_CMP;
      end
      S_DNRD: begin
        if (WB'(lchild) >= WB'(count_r)) begin
          state_nxt = S_DONE;
        end else begin
          hs_ra = SB'(lchild);
          lft_nxt = SB'(lchild);
          hasr_nxt = (WB'(lchild) + WB'(1)) < WB'(count_r);
          state_nxt = S_DNL;
        end
      end
      S_DNL: begin
        pr_ra = hs_rd;
        idl_nxt = hs_rd;
        hs_ra = lft_r + SB'(1);
        state_nxt = S_DNR;
      end
      S_DNR: begin
        // left priority arrives; request right priority
        pl_nxt = pr_rd;
        pr_ra = hs_rd;
        idb_nxt = hs_rd;
        state_nxt = S_DNSEL;
        if (!hasr_r) begin
          pb_nxt = pr_rd; idb_nxt = idl_r; oth_nxt = lft_r;
          state_nxt = S_CMP;
        end
      end
      S_DNSEL: begin
        // right priority ready: pick right only if strictly smaller
        if (lt) begin
          pb_nxt = pr_rd; oth_nxt = lft_r + SB'(1);
        end else begin
          pb_nxt = pl_r; idb_nxt = idl_r; oth_nxt = lft_r;
        end
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (lt) begin
          hs_we = 1'b1; hs_wa = oth_r; hs_wd = ida_r;
          ps_we = 1'b1; ps_wa = ida_r; ps_wd = oth_r;
          if (walk_r == imhq_pkg::WALK_CHANGE) walk_nxt = imhq_pkg::WALK_SWIM;
          state_nxt = S_SWAP2;
        end else if (walk_r == imhq_pkg::WALK_CHANGE) begin
          walk_nxt = imhq_pkg::WALK_SINK;
          state_nxt = S_DNRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SWAP2: begin
        // second half of a swap: neighbour goes into the walked item's old slot
        hs_we = 1'b1; hs_wa = pos_r; hs_wd = idb_r;
        ps_we = 1'b1; ps_wa = idb_r; ps_wd = pos_r;
        pos_nxt = oth_r;
        if (walk_r == imhq_pkg::WALK_SINK) state_nxt = S_DNRD;
        else state_nxt = S_UPRD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + IB'(1);
      if (state_r == S_DONE) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_tdata[2:0];
      id_r   <= in_tdata[12:3];
      prio_r <= req_prio;
    end
    walk_r <= walk_nxt;
    pos_r <= pos_nxt;   oth_r <= oth_nxt;   lft_r <= lft_nxt;
    ida_r <= ida_nxt;   idb_r <= idb_nxt;   idl_r <= idl_nxt;
    pa_r <= pa_nxt;     pb_r <= pb_nxt;     pl_r <= pl_nxt;
    hasr_r <= hasr_nxt;
    st_r <= st_nxt; io_r <= io_nxt; po_r <= po_nxt; mem_r <= mem_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {7'd0, 11'(count_r), mem_r, po_r, io_r, st_r};

endmodule
`default_nettype wire
